// ===== src/sha_pkg.sv =====
// Shared types and constants of the spike history archive.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  // Operation codes carried on in_tuser
  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_QUERY    = 2'd1;
  localparam logic [1:0] OP_RECORD   = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  localparam int OP_W       = 2;
  localparam int TIME_W     = 32;
  localparam int OFFS_W     = 16;
  localparam int RCNT_W     = 16;
  localparam int IDX_W      = 6;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 24;

  localparam logic [RCNT_W-1:0] RCNT_MAX = {RCNT_W{1'b1}};

  typedef logic [OP_W-1:0]   opcode_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [RCNT_W-1:0] rcnt_t;
  typedef logic [IDX_W-1:0]  idx_t;

endpackage
`default_nettype wire

// ===== src/spike_history_archive_top.sv =====
// Spike history archive: time-ordered spike FIFO with per-entry reader counts.
// Sequence: register reader and query scan entries in S_SCAN, record prunes consumed entries in
//   S_PRUNE before it appends, and each result is loaded in S_DONE; clear and a record with no
//   readers go straight to S_DONE. One entry per cycle through the history memories.
// Flow control: in_tready is low from accept until the result is loaded, so no new item is
//   taken while one is in progress; a result held back by out_tready stalls the next load.
// Reset: rst_n (synchronous, active low) empties the history and clears the reader total.
`timescale 1ns / 1ps
`default_nettype none
module spike_history_archive_top #(
  parameter int HISTORY_DEPTH = 32
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // in_tdata, lowest bit up: time_a[31:0], time_b[63:32], spike_offset[79:64]
  input  wire  [sha_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: opcode[1:0]
  input  wire  [sha_pkg::OP_W-1:0]         in_tuser,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // out_tdata, lowest bit up: first_index[5:0], end_index[11:6],
  // history_length[17:12], overflow[18], zero fill[23:19]
  output logic [sha_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready
);

  // Pointer into the ring and a count that can hold the full depth
  localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = CW + 1;

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_PRUNE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // History memories: spike times (one port) and per-entry read counts (separate read and write slots)
  sha_pkg::time_t spike_mem [HISTORY_DEPTH];
  sha_pkg::rcnt_t rcnt_mem  [HISTORY_DEPTH];

  logic [1:0]                      state_r, state_nxt;
  logic [CW-1:0]                   pos_r, pos_nxt;
  logic                            phase_r, phase_nxt;
  logic [PW-1:0]                   oldest_r, oldest_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  sha_pkg::rcnt_t                  total_r, total_nxt;
  sha_pkg::idx_t                   first_r, first_nxt;
  sha_pkg::idx_t                   end_r, end_nxt;
  logic                            ovf_r, ovf_nxt;
  sha_pkg::opcode_t                op_r, op_nxt;
  sha_pkg::time_t                  ta_r, ta_nxt;
  sha_pkg::time_t                  tb_r, tb_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [sha_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  // Registered memory read data and the slot it came from
  sha_pkg::time_t                  time_q;
  sha_pkg::rcnt_t                  rcnt_q;
  logic [PW-1:0]                   cur_slot_r;

  // Shared slot unit: (oldest + position) wrapped once into the ring
  logic [CW-1:0]                   slot_pos;
  logic [SW-1:0]                   slot_sum;
  logic [SW-1:0]                   slot_wrap;
  logic [PW-1:0]                   slot;

  logic                            accept;
  logic                            entry_ok;
  logic                            le_a;
  logic                            le_b;
  logic                            prune_go;
  logic                            bump_we;
  logic                            append_we;
  sha_pkg::rcnt_t                  rcnt_inc;
  sha_pkg::time_t                  in_ta;
  sha_pkg::time_t                  in_tb;
  logic [sha_pkg::OFFS_W-1:0]      in_off;
  sha_pkg::time_t                  rec_time;

  assign in_ta  = in_tdata[31:0];
  assign in_tb  = in_tdata[63:32];
  assign in_off = in_tdata[79:64];

  // Spike time after the offset, held at zero when the offset is larger
  assign rec_time = (in_ta >= sha_pkg::TIME_W'(in_off)) ?
                    (in_ta - sha_pkg::TIME_W'(in_off)) : '0;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign entry_ok = (pos_r < count_r);
  assign le_a     = (time_q <= ta_r);
  assign le_b     = (time_q <= tb_r);
  assign prune_go = (count_r > CW'(1)) && (rcnt_q >= total_r);
  assign rcnt_inc = (rcnt_q == sha_pkg::RCNT_MAX) ? rcnt_q : (rcnt_q + 1'b1);

  // Select the position the slot unit resolves this cycle
  always_comb begin
    case (state_r)
      S_SCAN:  slot_pos = CW'(pos_r + 1'b1);
      S_PRUNE: slot_pos = prune_go ? CW'(1) : count_r;
      default: slot_pos = '0;
    endcase
  end

  assign slot_sum  = SW'(oldest_r) + SW'(slot_pos);
  assign slot_wrap = (slot_sum >= SW'(HISTORY_DEPTH)) ?
                     (slot_sum - SW'(HISTORY_DEPTH)) : slot_sum;
  assign slot      = slot_wrap[PW-1:0];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    first_nxt     = first_r;
    end_nxt       = end_r;
    ovf_nxt       = ovf_r;
    op_nxt        = op_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    bump_we       = 1'b0;
    append_we     = 1'b0;

    // Drop the result once taken; a new load below overrides this
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_tuser;
          ta_nxt    = (in_tuser == sha_pkg::OP_RECORD) ? rec_time : in_ta;
          tb_nxt    = in_tb;
          pos_nxt   = '0;
          phase_nxt = 1'b0;
          first_nxt = '0;
          end_nxt   = '0;
          ovf_nxt   = 1'b0;
          case (in_tuser)
            sha_pkg::OP_REGISTER,
            sha_pkg::OP_QUERY: begin
              state_nxt = S_SCAN;
            end
            sha_pkg::OP_RECORD: begin
              state_nxt = (total_r != '0) ? S_PRUNE : S_DONE;
            end
            default: begin
              count_nxt  = '0;
              oldest_nxt = '0;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (op_r == sha_pkg::OP_REGISTER) begin
          if (entry_ok && le_a) begin
            bump_we = 1'b1;
            pos_nxt = CW'(pos_r + 1'b1);
          end else begin
            if (total_r != sha_pkg::RCNT_MAX) begin
              total_nxt = total_r + 1'b1;
            end
            state_nxt = S_DONE;
          end
        end else begin
          if (!entry_ok) begin
            if (!phase_r) begin
              first_nxt = sha_pkg::IDX_W'(pos_r);
            end
            end_nxt   = sha_pkg::IDX_W'(pos_r);
            state_nxt = S_DONE;
          end else if (!phase_r && le_a) begin
            pos_nxt = CW'(pos_r + 1'b1);
          end else if (le_b) begin
            if (!phase_r) begin
              first_nxt = sha_pkg::IDX_W'(pos_r);
            end
            phase_nxt = 1'b1;
            bump_we   = 1'b1;
            pos_nxt   = CW'(pos_r + 1'b1);
          end else begin
            if (!phase_r) begin
              first_nxt = sha_pkg::IDX_W'(pos_r);
            end
            end_nxt   = sha_pkg::IDX_W'(pos_r);
            state_nxt = S_DONE;
          end
        end
      end

      S_PRUNE: begin
        if (prune_go) begin
          // Advance past an oldest entry that every reader has consumed
          oldest_nxt = slot;
          count_nxt  = CW'(count_r - 1'b1);
        end else begin
          if (count_r >= CW'(HISTORY_DEPTH)) begin
            ovf_nxt = 1'b1;
          end else begin
            append_we = 1'b1;
            count_nxt = CW'(count_r + 1'b1);
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sha_pkg::OUT_DATA_W'({ovf_r, sha_pkg::IDX_W'(count_r),
                                                end_r, first_r});
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      phase_r     <= 1'b0;
      oldest_r    <= '0;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r    <= first_nxt;
    end_r      <= end_nxt;
    ovf_r      <= ovf_nxt;
    op_r       <= op_nxt;
    ta_r       <= ta_nxt;
    tb_r       <= tb_nxt;
    out_data_r <= out_data_nxt;
    cur_slot_r <= slot;
  end

  // Spike time memory: append writes, one registered read per cycle
  always_ff @(posedge clk) begin
    if (append_we) begin
      spike_mem[slot] <= ta_r;
    end
    time_q <= spike_mem[slot];
  end

  // Read count memory: bump writes back to the slot just read, append clears
  always_ff @(posedge clk) begin
    if (bump_we) begin
      rcnt_mem[cur_slot_r] <= rcnt_inc;
    end else if (append_we) begin
      rcnt_mem[slot] <= '0;
    end
    rcnt_q <= rcnt_mem[slot];
  end

endmodule
`default_nettype wire

// ===== tb/sha_archive_checker.sv =====
// Scoreboard for the spike history archive: predicts every result and compares it.
`timescale 1ns / 1ps
module sha_archive_checker #(
  parameter int HISTORY_DEPTH = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  [sha_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire  [sha_pkg::OP_W-1:0]           in_tuser,
  input  wire                                in_tvalid,
  input  wire                                in_tready,
  input  wire  [sha_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire                                out_tvalid,
  input  wire                                out_tready,
  output int                                 mismatch_count,
  output int                                 results_pending
);

  // Results still owed by the block; a sequential block owes at most two
  localparam int EXPECT_DEPTH = 8;

  typedef struct packed {
    logic          overflow;
    sha_pkg::idx_t length;
    sha_pkg::idx_t end_idx;
    sha_pkg::idx_t first_idx;
  } archive_result_t;

  // Shadow copy of the archive
  sha_pkg::time_t  stored_time [HISTORY_DEPTH];
  sha_pkg::rcnt_t  read_tally  [HISTORY_DEPTH];
  int unsigned     oldest;
  int unsigned     fill_level;
  sha_pkg::rcnt_t  reader_total;
  archive_result_t expect_buf [EXPECT_DEPTH];
  int unsigned     expect_rd;
  int unsigned     expect_wr;
  int unsigned     expect_level;
  int              fails = 0;

  function automatic int unsigned ring_slot(int unsigned pos);
    return (oldest + pos) % HISTORY_DEPTH;
  endfunction

  function automatic void bump_reads(int unsigned slot);
    if (read_tally[slot] != sha_pkg::RCNT_MAX) read_tally[slot] = read_tally[slot] + 1'b1;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  task automatic archive_apply(input sha_pkg::opcode_t op, input sha_pkg::time_t ta,
                               input sha_pkg::time_t tb,
                               input logic [sha_pkg::OFFS_W-1:0] offs,
                               output archive_result_t res);
    int unsigned pos;
    int unsigned slot;
    res = '0;
    pos = 0;
    case (op)
      sha_pkg::OP_REGISTER: begin
        while (pos < fill_level && stored_time[ring_slot(pos)] <= ta) begin
          bump_reads(ring_slot(pos));
          pos++;
        end
        if (reader_total != sha_pkg::RCNT_MAX) reader_total = reader_total + 1'b1;
      end
      sha_pkg::OP_QUERY: begin
        while (pos < fill_level && stored_time[ring_slot(pos)] <= ta) pos++;
        res.first_idx = sha_pkg::idx_t'(pos);
        while (pos < fill_level && stored_time[ring_slot(pos)] <= tb) begin
          bump_reads(ring_slot(pos));
          pos++;
        end
        res.end_idx = sha_pkg::idx_t'(pos);
      end
      sha_pkg::OP_RECORD: begin
        if (reader_total != '0) begin
          // drop fully consumed entries from the front, always keep one
          while (fill_level > 1 && read_tally[oldest] >= reader_total) begin
            oldest = (oldest + 1) % HISTORY_DEPTH;
            fill_level--;
          end
          if (fill_level >= HISTORY_DEPTH) begin
            res.overflow = 1'b1;
          end else begin
            slot = ring_slot(fill_level);
            stored_time[slot] = (ta >= sha_pkg::time_t'(offs)) ?
                                ta - sha_pkg::time_t'(offs) : '0;
            read_tally[slot] = '0;
            fill_level++;
          end
        end
      end
      sha_pkg::OP_CLEAR: begin
        fill_level = 0;
        oldest = 0;
      end
      default: begin
        $display("%0t: unknown opcode: expected 0 to 3, actual %b", $time, op);
        fails++;
      end
    endcase
    res.length = sha_pkg::idx_t'(fill_level);
  endtask

  always @(posedge clk) begin : watch
    archive_result_t want;
    if (!rst_n) begin
      oldest = 0;
      fill_level = 0;
      reader_total = '0;
      expect_rd = 0;
      expect_wr = 0;
      expect_level = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expect_level == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, out_tdata);
          fails++;
        end else begin
          want = expect_buf[expect_rd];
          expect_rd = (expect_rd + 1) % EXPECT_DEPTH;
          expect_level--;
          check_field("first_index", want.first_idx, out_tdata[5:0]);
          check_field("end_index", want.end_idx, out_tdata[11:6]);
          check_field("history_length", want.length, out_tdata[17:12]);
          check_field("overflow", want.overflow, out_tdata[18]);
          check_field("zero fill", '0, out_tdata[sha_pkg::OUT_DATA_W-1:19]);
        end
      end
      if (in_tvalid && in_tready) begin
        archive_apply(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[79:64], want);
        if (expect_level == EXPECT_DEPTH) begin
          $display("%0t: result backlog: expected at most %0d, actual %0d", $time,
                   EXPECT_DEPTH, expect_level + 1);
          fails++;
        end else begin
          expect_buf[expect_wr] = want;
          expect_wr = (expect_wr + 1) % EXPECT_DEPTH;
          expect_level++;
        end
      end
    end
    mismatch_count  <= fails;
    results_pending <= int'(expect_level);
  end

endmodule

// ===== tb/tb_spike_history_archive_top.sv =====
// Testbench top for the spike history archive: stimulus, stalls and the verdict.
`timescale 1ns / 1ps
module tb_spike_history_archive_top;

  localparam int DEPTH         = 32;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AFTER    = 150;
  localparam int DRAIN_CYCLES  = 2 * DEPTH + 16;
  // cycle budget for the hang guard, with a wide margin over a full run
  localparam int CYCLE_LIMIT   = 500_000;

  logic                           clk;
  logic                           rst_n;
  // in_tdata, lowest bit up: time_a[31:0], time_b[63:32], spike_offset[79:64]
  logic [sha_pkg::IN_DATA_W-1:0]  in_tdata;
  // in_tuser: opcode[1:0]
  sha_pkg::opcode_t               in_tuser;
  logic                           in_tvalid;
  logic                           in_tready;
  // out_tdata, lowest bit up: first_index[5:0], end_index[11:6],
  // history_length[17:12], overflow[18], zero fill[23:19]
  logic [sha_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tvalid;
  logic                           out_tready;

  int             mismatch_count;
  int             results_pending;
  // idle odds in percent, changed by the stimulus between phases
  int             send_idle_pct;
  int             recv_stall_pct;
  int unsigned    cycle_count;
  // running spike clock that keeps most records in time order
  sha_pkg::time_t spike_clock;

  spike_history_archive_top #(
    .HISTORY_DEPTH(DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  sha_archive_checker #(
    .HISTORY_DEPTH(DEPTH)
  ) scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hang guard: give up once the cycle budget is spent.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Result sink: random stalls, plus one long hold-off after a while so the block
  // backs up and holds in_tready low while the sender keeps offering.
  initial begin : result_sink
    int results_taken;
    int hold_left;
    bit hold_done;
    results_taken = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    out_tready    = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) results_taken++;
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one item; return at the edge where it is accepted. Valid stays high if the
  // next call offers again at once, so it is never dropped and raised in one step.
  task automatic offer_op(input sha_pkg::opcode_t op, input sha_pkg::time_t ta,
                          input sha_pkg::time_t tb,
                          input logic [sha_pkg::OFFS_W-1:0] offs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {offs, tb, ta};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin : stimulus
    int               sent;
    int               pick;
    int               burst_left;
    sha_pkg::opcode_t op;
    sha_pkg::time_t   ta;
    sha_pkg::time_t   tb;
    logic [15:0]      offs;

    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = sha_pkg::OP_CLEAR;
    send_idle_pct  = 25;
    recv_stall_pct = 78;
    spike_clock    = 32'd1000;
    sent           = 0;
    burst_left     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, records with no readers, negative spike times,
    // extreme times and offsets, an inverted query window, pruning, clear.
    offer_op(sha_pkg::OP_CLEAR,    '0, '0, '0);
    offer_op(sha_pkg::OP_QUERY,    '0, '1, '0);
    offer_op(sha_pkg::OP_RECORD,   32'd1000, '0, '0);       // no readers yet: ignored
    offer_op(sha_pkg::OP_REGISTER, '0, '0, '0);
    offer_op(sha_pkg::OP_RECORD,   32'd100, '0, 16'd200);   // clamps to zero
    offer_op(sha_pkg::OP_RECORD,   '1, '0, '0);
    offer_op(sha_pkg::OP_RECORD,   32'h0001_000A, '0, '1);
    offer_op(sha_pkg::OP_QUERY,    '0, 32'hFFFF_FFFE, '0);
    offer_op(sha_pkg::OP_QUERY,    '1, '1, '1);
    offer_op(sha_pkg::OP_QUERY,    '0, '1, '0);
    offer_op(sha_pkg::OP_QUERY,    32'd20, 32'd5, '0);      // upper below lower
    offer_op(sha_pkg::OP_REGISTER, '1, '0, '0);
    offer_op(sha_pkg::OP_REGISTER, '0, '0, '0);
    offer_op(sha_pkg::OP_RECORD,   32'd500, '1, 16'd100);   // front entry not read by every reader yet: kept
    offer_op(sha_pkg::OP_RECORD,   32'hAAAA_AAAA, 32'h5555_5555, 16'h5555);
    offer_op(sha_pkg::OP_REGISTER, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA);
    offer_op(sha_pkg::OP_QUERY,    32'h5555_5555, 32'hAAAA_AAAA, '0);
    offer_op(sha_pkg::OP_CLEAR,    '1, '1, '1);
    offer_op(sha_pkg::OP_QUERY,    '0, '1, '0);
    offer_op(sha_pkg::OP_RECORD,   32'd2000, '0, '0);
    offer_op(sha_pkg::OP_REGISTER, 32'd1999, '0, '0);

    // Random part in three idle phases. Mostly ordered spikes with readers and
    // queries around the recent past; bursts of records push the store to full.
    while (sent < RANDOM_ITEMS) begin
      if (sent == RANDOM_ITEMS / 3) begin
        send_idle_pct  = 78;
        recv_stall_pct = 25;
      end else if (sent == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (burst_left > 0) begin
        burst_left--;
        pick = 0;
      end else begin
        pick = $urandom_range(99);
        if (pick < 3) burst_left = $urandom_range(45, 20);
      end
      ta   = $urandom;
      tb   = $urandom;
      offs = 16'($urandom);
      if (pick < 40) begin
        op = sha_pkg::OP_RECORD;
        spike_clock = spike_clock + $urandom_range(2000, 1);
        ta = spike_clock;
        if ($urandom_range(9) != 0) offs = 16'($urandom_range(3000));
      end else if (pick < 58) begin
        op = sha_pkg::OP_QUERY;
        ta = spike_clock - $urandom_range(40000);
        tb = ta + $urandom_range(60000);
      end else if (pick < 65) begin
        // sweep: query from time zero up to the spike clock or the top of the range
        op = sha_pkg::OP_QUERY;
        ta = '0;
        tb = ($urandom_range(1) != 0) ? spike_clock : '1;
      end else if (pick < 80) begin
        op = sha_pkg::OP_REGISTER;
        ta = spike_clock - $urandom_range(30000);
      end else if (pick < 84) begin
        op = sha_pkg::OP_CLEAR;
      end else if (pick < 86) begin
        // jump the spike clock so high time bits get exercised in order too
        op = sha_pkg::OP_RECORD;
        spike_clock = $urandom;
        ta = spike_clock;
      end else begin
        op = sha_pkg::opcode_t'($urandom_range(3));
      end
      offer_op(op, ta, tb, offs);
      sent++;
    end
    in_tvalid <= 1'b0;

    // Drain: let the checker see the last accept, wait for every result, then
    // give stray results a chance to show up.
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sha_pkg.sv
src/spike_history_archive_top.sv
tb/sha_archive_checker.sv
tb/tb_spike_history_archive_top.sv
